// File: design/hsf_pkg.sv
// Shared types and constants for the hard sphere structure factor block.
// Holds the sequencer state type, fixed-point constants and the sine table.
// No dependencies.
package hsf_pkg;

   localparam int STEP_W  = 13;
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = 96;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 48;
   localparam int DIV_C_W = 7;

   localparam logic [28:0] ONE_Q28    = 29'h1000_0000;
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [31:0] PI_SIXTH   = 32'd2248839617;
   localparam logic [31:0] INV_TWO_PI = 32'd683565276;
   localparam logic [31:0] S_MAX      = 32'h7FFF_FFFF;

   // quotient bit counts for the divider
   localparam logic [DIV_C_W-1:0] DBITS_F    = 7'd29;
   localparam logic [DIV_C_W-1:0] DBITS_X    = 7'd32;
   localparam logic [DIV_C_W-1:0] DBITS_SINC = 7'd47;
   localparam logic [DIV_C_W-1:0] DBITS_T    = 7'd48;
   localparam logic [DIV_C_W-1:0] DBITS_S    = 7'd53;

   localparam logic [1:0] CSR_N_STEPS  = 2'd0;
   localparam logic [1:0] CSR_DIAMETER = 2'd1;
   localparam logic [1:0] CSR_DENSITY  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE, ST_WAIT, ST_DENS, ST_A, ST_B, ST_C, ST_PF, ST_OM2, ST_OM4,
      ST_HO, ST_HOP, ST_CB, ST_CG, ST_QS, ST_FDIV, ST_XDIV, ST_STEP, ST_FSQ,
      ST_F2, ST_F3, ST_CBF, ST_CGF, ST_PHASE, ST_T2, ST_HORNER, ST_SINE,
      ST_SINC, ST_TERM, ST_TERM2, ST_ACCUM, ST_TDIV, ST_PFTT, ST_DEN,
      ST_SDIV, ST_DONE
   } state_type;

   // odd Taylor coefficients of the sine over a quarter wave, Q.30
   function automatic logic [31:0] sin_coef(input logic [2:0] k);
      logic [31:0] c;
      case (k)
         3'd0:    c = 32'd1686629713;
         3'd1:    c = 32'd693598668;
         3'd2:    c = 32'd85569306;
         3'd3:    c = 32'd5026995;
         3'd4:    c = 32'd172272;
         default: c = 32'd0;
      endcase
      return c;
   endfunction

endpackage

// File: design/hard_sphere_structure_factor.sv
// Top level of the Percus-Yevick hard sphere structure factor S(q).
// Depends on hsf_pkg, hsf_mul and hsf_div.
//
// Usage: write n_steps, sphere_diameter and number_density on the csr_ port
// while the block is idle (index 0, 1, 2; other indexes are ignored). Present
// q on req_scatter_q with req_valid; the request is taken when req_stall is
// low. req_stall stays high during reset and while one request is worked, so
// one q is in flight at a time. The result appears on rsp_factor_value (signed
// Q8.24) and rsp_out_of_range with rsp_valid and holds while rsp_stall is high.
// A result waiting on a stalled receiver does not block the next request;
// only the finish of that next request waits for the output register.
// Timing: one sequencer pass on a shared 64 x 33 multiplier and a one bit per
// cycle divider. The sine and its divide dominate each integration point (a
// zero argument skips them), and the request ends with the final two divides.
// Reset: synchronous, restores the register defaults (100, 1.0, 0) and
// drops any request in progress and any pending result.
module hard_sphere_structure_factor
   import hsf_pkg::*;
#(
   parameter int MAX_STEPS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_scatter_q,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_factor_value,
   output logic        rsp_out_of_range,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   state_type state_ff, state_in, ret_ff, ret_in;

   // configuration
   logic [STEP_W-1:0] nsteps_ff;
   logic [23:0]       diam_ff;
   logic [31:0]       dens_ff;

   // per request values
   logic [23:0]       q_ff;
   logic [STEP_W-1:0] nn_ff;
   logic [27:0]       pf_ff;
   logic [28:0]       om4_ff;
   logic [31:0]       ho_ff;
   logic [32:0]       cb_ff;
   logic [30:0]       cg_ff;
   logic [31:0]       qs_ff;
   logic [28:0]       fq_ff;
   logic [STEP_W-1:0] fr_ff;
   logic [31:0]       xq_ff;
   logic [STEP_W-1:0] xr_ff;

   // integration loop
   logic [STEP_W-1:0] i_ff;
   logic [28:0]       facc_ff;
   logic [STEP_W-1:0] frac_ff;
   logic [31:0]       xacc_ff;
   logic [STEP_W-1:0] xrac_ff;
   logic [28:0]       f2_ff;
   logic [28:0]       f3_ff;
   logic [32:0]       cbf_ff;
   logic signed [35:0] poly_ff;
   logic [30:0]       t_ff;
   logic [30:0]       t2_ff;
   logic [1:0]        quad_ff;
   logic [1:0]        k_ff;
   logic signed [31:0] sinc_ff;
   logic signed [47:0] sum_ff;

   logic [31:0]       fin_val_ff;
   logic              fin_ovf_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_val_ff;
   logic              rsp_ovf_ff;

   // shared units
   logic                       mul_start, mul_busy;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mres;
   logic                       div_start, div_busy;
   logic [DIV_N_W-1:0]         div_dividend, div_quo;
   logic [DIV_D_W-1:0]         div_divisor, div_rem;
   logic [DIV_C_W-1:0]         div_nbits;

   // combinational helpers
   logic              accept, out_free, units_idle, big_hi, last_step, den_pos;
   logic [STEP_W-1:0] n0, nn_w;
   logic [28:0]       om_w, a2_w;
   logic [29:0]       a1_w;
   logic [31:0]       ph_w;
   logic [30:0]       t_w;
   logic [31:0]       u_w;
   logic [31:0]       y_w;
   logic [30:0]       ycl_w;
   logic [30:0]       qcl_w;
   logic [47:0]       sabs_w;
   logic signed [35:0] tt_w;
   logic signed [47:0] w_w, den_w;
   logic [STEP_W:0]   fsum_w, xsum_w;
   logic              fwrap_w, xwrap_w;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign units_idle = !mul_busy && !div_busy;
   assign big_hi     = |mres[95:64];
   assign last_step  = (i_ff == nn_ff);

   assign n0   = (nsteps_ff == '0) ? STEP_W'(1) : nsteps_ff;
   assign nn_w = (32'(n0) > 32'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : n0;

   assign om_w = ONE_Q28 - {1'b0, mres[63:36]};
   assign a1_w = 30'(ONE_Q28) + {1'b0, pf_ff, 1'b0};
   assign a2_w = ONE_Q28 + 29'(pf_ff[27:1]);

   // fold the phase into a quarter wave
   assign ph_w = mres[47:16];
   assign t_w  = ph_w[30] ? (ONE_Q30 - {1'b0, ph_w[29:0]}) : {1'b0, ph_w[29:0]};
   assign u_w  = sin_coef({1'b0, k_ff}) - {1'b0, mres[60:30]};
   assign y_w  = mres[61:30];
   assign ycl_w = (y_w > 32'(ONE_Q30)) ? ONE_Q30 : y_w[30:0];
   assign qcl_w = (div_quo > 64'(ONE_Q30)) ? ONE_Q30 : div_quo[30:0];

   assign sabs_w = sum_ff[47] ? 48'(-sum_ff) : 48'(sum_ff);
   assign tt_w   = sum_ff[47] ? -$signed(div_quo[35:0]) : $signed(div_quo[35:0]);
   assign w_w    = 48'($signed(mres[67:28]));
   assign den_w  = $signed(48'(om4_ff)) - (w_w <<< 4) - (w_w <<< 3);
   assign den_pos = !den_w[47] && (den_w != '0);

   // incremental i*K/n: add the quotient, carry when the remainder wraps
   assign fsum_w  = {1'b0, frac_ff} + {1'b0, fr_ff};
   assign xsum_w  = {1'b0, xrac_ff} + {1'b0, xr_ff};
   assign fwrap_w = fsum_w >= {1'b0, nn_ff};
   assign xwrap_w = xsum_w >= {1'b0, nn_ff};

   hsf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .product (mres)
   );

   hsf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .nbits     (div_nbits),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DENS;
         ST_WAIT:   if (units_idle) state_in = ret_ff;
         ST_C, ST_PF: state_in = big_hi ? ST_DONE : ST_WAIT;
         ST_XDIV:   state_in = ST_STEP;
         ST_STEP:   state_in = ST_FSQ;
         ST_CGF:    state_in = (xacc_ff == '0) ? ST_TERM : ST_WAIT;
         ST_SINC:   state_in = ST_TERM;
         ST_ACCUM:  state_in = last_step ? ST_TDIV : ST_STEP;
         ST_DEN:    state_in = den_pos ? ST_WAIT : ST_DONE;
         ST_SDIV:   state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_WAIT;
      endcase
   end

   // unit commands: a state issues at most one operation and names where to resume
   always_comb begin
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_nbits    = '0;
      ret_in       = ret_ff;
      unique case (state_ff)
         ST_DENS: begin
            mul_start = 1'b1; mul_a = 64'(dens_ff); mul_b = 33'(diam_ff); ret_in = ST_A;
         end
         ST_A: begin
            mul_start = 1'b1; mul_a = 64'(mres[55:16]); mul_b = 33'(diam_ff); ret_in = ST_B;
         end
         ST_B: begin
            mul_start = 1'b1; mul_a = 64'(mres[63:16]); mul_b = 33'(diam_ff); ret_in = ST_C;
         end
         ST_C: begin
            mul_start = !big_hi; mul_a = 64'(mres[63:8]); mul_b = 33'(PI_SIXTH);
            ret_in = ST_PF;
         end
         ST_PF: begin
            mul_start = !big_hi; mul_a = 64'(om_w); mul_b = 33'(om_w); ret_in = ST_OM2;
         end
         ST_OM2: begin
            mul_start = 1'b1; mul_a = 64'(mres[56:28]); mul_b = 33'(mres[56:28]);
            ret_in = ST_OM4;
         end
         ST_OM4: begin
            mul_start = 1'b1; mul_a = 64'(a1_w); mul_b = 33'(a1_w); ret_in = ST_HO;
         end
         ST_HO: begin
            mul_start = 1'b1; mul_a = 64'(a2_w); mul_b = 33'(a2_w); ret_in = ST_HOP;
         end
         ST_HOP: begin
            mul_start = 1'b1; mul_a = 64'(mres[57:28]); mul_b = 33'(pf_ff); ret_in = ST_CB;
         end
         ST_CB: begin
            mul_start = 1'b1; mul_a = 64'(ho_ff); mul_b = 33'(pf_ff); ret_in = ST_CG;
         end
         ST_CG: begin
            mul_start = 1'b1; mul_a = 64'(q_ff); mul_b = 33'(diam_ff); ret_in = ST_QS;
         end
         ST_QS: begin
            div_start = 1'b1; div_dividend = 64'(ONE_Q28); div_divisor = 48'(nn_ff);
            div_nbits = DBITS_F; ret_in = ST_FDIV;
         end
         ST_FDIV: begin
            div_start = 1'b1; div_dividend = 64'(qs_ff); div_divisor = 48'(nn_ff);
            div_nbits = DBITS_X; ret_in = ST_XDIV;
         end
         ST_FSQ: begin
            mul_start = 1'b1; mul_a = 64'(facc_ff); mul_b = 33'(facc_ff); ret_in = ST_F2;
         end
         ST_F2: begin
            mul_start = 1'b1; mul_a = 64'(mres[56:28]); mul_b = 33'(facc_ff); ret_in = ST_F3;
         end
         ST_F3: begin
            mul_start = 1'b1; mul_a = 64'(cb_ff); mul_b = 33'(facc_ff); ret_in = ST_CBF;
         end
         ST_CBF: begin
            mul_start = 1'b1; mul_a = 64'(cg_ff); mul_b = 33'(f3_ff); ret_in = ST_CGF;
         end
         ST_CGF: begin
            mul_start = (xacc_ff != '0); mul_a = 64'(xacc_ff); mul_b = 33'(INV_TWO_PI);
            ret_in = ST_PHASE;
         end
         ST_PHASE: begin
            mul_start = 1'b1; mul_a = 64'(t_w); mul_b = 33'(t_w); ret_in = ST_T2;
         end
         ST_T2: begin
            mul_start = 1'b1; mul_a = 64'(mres[60:30]); mul_b = 33'(sin_coef(3'd4));
            ret_in = ST_HORNER;
         end
         ST_HORNER: begin
            mul_start = 1'b1;
            mul_a     = 64'(u_w);
            mul_b     = (k_ff == 2'd0) ? 33'(t_ff) : 33'(t2_ff);
            ret_in    = (k_ff == 2'd0) ? ST_SINE : ST_HORNER;
         end
         ST_SINE: begin
            div_start = 1'b1; div_dividend = 64'({ycl_w, 16'b0});
            div_divisor = 48'(xacc_ff); div_nbits = DBITS_SINC; ret_in = ST_SINC;
         end
         ST_TERM: begin
            mul_start = 1'b1; mul_a = 64'(sinc_ff); mul_b = 33'(f2_ff); ret_in = ST_TERM2;
         end
         ST_TERM2: begin
            mul_start = 1'b1; mul_a = 64'(poly_ff); mul_b = 33'($signed(mres[61:30]));
            ret_in = ST_ACCUM;
         end
         ST_TDIV: begin
            div_start = 1'b1; div_dividend = 64'(sabs_w); div_divisor = 48'(nn_ff);
            div_nbits = DBITS_T; ret_in = ST_PFTT;
         end
         ST_PFTT: begin
            mul_start = 1'b1; mul_a = 64'(tt_w); mul_b = 33'(pf_ff); ret_in = ST_DEN;
         end
         ST_DEN: begin
            div_start = den_pos; div_dividend = 64'({om4_ff, 24'b0});
            div_divisor = den_w[47:0]; div_nbits = DBITS_S; ret_in = ST_SDIV;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         nsteps_ff <= STEP_W'(100);
         diam_ff   <= 24'd65536;
         dens_ff   <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_N_STEPS:  nsteps_ff <= csr_data[STEP_W-1:0];
            CSR_DIAMETER: diam_ff   <= csr_data[23:0];
            CSR_DENSITY:  dens_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // datapath: capture the request and what the previous operation produced, and step the loop
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            q_ff  <= req_scatter_q;
            nn_ff <= nn_w;
         end
         ST_C: if (big_hi) begin
            fin_val_ff <= S_MAX;
            fin_ovf_ff <= 1'b1;
         end
         ST_PF: begin
            pf_ff <= mres[63:36];
            if (big_hi) begin
               fin_val_ff <= S_MAX;
               fin_ovf_ff <= 1'b1;
            end
         end
         ST_OM4:  om4_ff <= mres[56:28];
         ST_HO:   ho_ff  <= mres[59:28];
         ST_CB:   cb_ff  <= 33'({mres[57:28], 2'b00}) + 33'({mres[57:28], 1'b0});
         ST_CG:   cg_ff  <= mres[59:29];
         ST_QS:   qs_ff  <= mres[47:16];
         ST_FDIV: begin
            fq_ff <= div_quo[28:0];
            fr_ff <= div_rem[STEP_W-1:0];
         end
         ST_XDIV: begin
            xq_ff   <= div_quo[31:0];
            xr_ff   <= div_rem[STEP_W-1:0];
            i_ff    <= '0;
            facc_ff <= '0;
            frac_ff <= '0;
            xacc_ff <= '0;
            xrac_ff <= '0;
            sum_ff  <= '0;
         end
         ST_STEP: begin
            i_ff    <= i_ff + 1'b1;
            facc_ff <= facc_ff + fq_ff + 29'(fwrap_w);
            frac_ff <= fwrap_w ? STEP_W'(fsum_w - {1'b0, nn_ff}) : fsum_w[STEP_W-1:0];
            xacc_ff <= xacc_ff + xq_ff + 32'(xwrap_w);
            xrac_ff <= xwrap_w ? STEP_W'(xsum_w - {1'b0, nn_ff}) : xsum_w[STEP_W-1:0];
         end
         ST_F2:  f2_ff  <= mres[56:28];
         ST_F3:  f3_ff  <= mres[56:28];
         ST_CBF: cbf_ff <= mres[60:28];
         ST_CGF: begin
            poly_ff <= $signed(36'(cbf_ff) - 36'(ho_ff) - 36'(mres[58:28]));
            sinc_ff <= $signed(32'(ONE_Q30));
         end
         ST_PHASE: begin
            quad_ff <= ph_w[31:30];
            t_ff    <= t_w;
         end
         ST_T2: begin
            t2_ff <= mres[60:30];
            k_ff  <= 2'd3;
         end
         ST_HORNER: k_ff <= k_ff - 2'd1;
         ST_SINC: sinc_ff <= quad_ff[1] ? -$signed(32'(qcl_w)) : $signed(32'(qcl_w));
         ST_ACCUM: sum_ff <= sum_ff + $signed(mres[75:28]);
         ST_DEN: if (!den_pos) begin
            fin_val_ff <= S_MAX;
            fin_ovf_ff <= 1'b1;
         end
         ST_SDIV: begin
            fin_val_ff <= (div_quo > 64'(S_MAX)) ? S_MAX : div_quo[31:0];
            fin_ovf_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   // output register: load when free, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_val_ff   <= fin_val_ff;
         rsp_ovf_ff   <= fin_ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold off requests during reset and while a request is worked
   assign req_stall        = reset || (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_value = rsp_val_ff;
   assign rsp_out_of_range = rsp_ovf_ff;

endmodule

// File: design/hsf_mul.sv
// Shared signed multiplier, 64 x 33 bits, built from two 32 x 32 partial products.
// Depends on hsf_pkg.
module hsf_mul
   import hsf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic                      busy,
   output logic signed [MUL_P_W-1:0] product
);

   logic [63:0]              a_abs;
   logic [32:0]              b_abs;
   logic [62:0]              am_ff;
   logic [31:0]              bm_ff;
   logic                     neg_ff;
   logic [1:0]               cnt_ff;
   logic                     busy_ff;
   logic [63:0]              pp_ff;
   logic [94:0]              acc_ff;
   logic signed [MUL_P_W-1:0] prod_ff;

   assign a_abs = op_a[MUL_A_W-1] ? 64'(-op_a) : 64'(op_a);
   assign b_abs = op_b[MUL_B_W-1] ? 33'(-op_b) : 33'(op_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 2'd0;
         am_ff   <= a_abs[62:0];
         bm_ff   <= b_abs[31:0];
         neg_ff  <= op_a[MUL_A_W-1] ^ op_b[MUL_B_W-1];
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 2'd1;
         unique case (cnt_ff)
            2'd0: pp_ff <= 64'(am_ff[31:0]) * 64'(bm_ff);
            2'd1: begin
               acc_ff <= 95'(pp_ff);
               pp_ff  <= 64'(am_ff[62:32]) * 64'(bm_ff);
            end
            2'd2: acc_ff <= acc_ff + {pp_ff[62:0], 32'b0};
            2'd3: begin
               prod_ff <= neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
               busy_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy    = busy_ff;
   assign product = prod_ff;

endmodule

// File: design/hsf_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on hsf_pkg.
module hsf_div
   import hsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   input  logic [DIV_C_W-1:0] nbits,
   output logic               busy,
   output logic [DIV_N_W-1:0] quotient,
   output logic [DIV_D_W-1:0] remainder
);

   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] dsr_ff;
   logic [DIV_C_W-1:0] cnt_ff;
   logic               busy_ff;
   logic [DIV_C_W-1:0] lshift;
   logic [DIV_D_W+1:0] diff;

   assign lshift = DIV_C_W'(DIV_N_W) - nbits;
   assign diff   = {1'b0, rem_ff, quo_ff[DIV_N_W-1]} - {2'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= nbits;
         quo_ff  <= dividend << lshift[5:0];
         rem_ff  <= '0;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         // keep the trial difference only when it does not go negative
         if (!diff[DIV_D_W+1]) begin
            rem_ff <= diff[DIV_D_W-1:0];
            quo_ff <= {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DIV_D_W-2:0], quo_ff[DIV_N_W-1]};
            quo_ff <= {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == DIV_C_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: test/tb_hard_sphere_structure_factor.sv
`timescale 1ns / 1ps
// Testbench for hard_sphere_structure_factor: directed and random requests
// checked against a predictor of S(q). Depends on hsf_pkg and the design.
module tb_hard_sphere_structure_factor
   import hsf_pkg::*;
();

   localparam int  MAX_STEPS   = 4096;
   localparam int  CYCLE_LIMIT = 20_000_000;
   localparam int  DRAIN_WAIT  = 400;
   localparam longint unsigned SIN_COEF [5] = '{
      64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272};
   localparam longint unsigned PI6_Q32   = 64'd2248839617;
   localparam longint unsigned TURN_RATE = 64'd683565276;
   localparam longint ONE_F   = 64'sd268435456;
   localparam longint ONE_S30 = 64'sd1073741824;
   localparam longint S_TOP   = 64'sd2147483647;

   typedef struct packed {
      logic [23:0] q;
      logic [31:0] value;
      logic        oor;
   } factor_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_scatter_q = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_factor_value;
   logic        rsp_out_of_range;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor copy of the register file
   logic [12:0] steps_reg;
   logic [23:0] diameter_reg;
   logic [31:0] density_reg;

   factor_type factor_queue [$];
   int      mismatches = 0;
   int      cycles = 0;
   bit      calm = 1'b0;   // when set, neither side idles
   int      stall_left = 0;

   hard_sphere_structure_factor #(.MAX_STEPS(MAX_STEPS)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_scatter_q,
      .rsp_valid, .rsp_stall, .rsp_factor_value, .rsp_out_of_range,
      .csr_write, .csr_index, .csr_data);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sine of a phase in turns (Q.32), result signed Q.30
   function automatic longint sine_q30(input logic [31:0] phase);
      logic [1:0] quad;
      longint unsigned r, t, t2, u, y;
      quad = phase[31:30];
      r = {34'd0, phase[29:0]};
      t = quad[0] ? (64'd1073741824 - r) : r;
      t2 = (t * t) >> 30;
      u = SIN_COEF[4];
      for (int k = 3; k >= 0; k--) u = SIN_COEF[k] - ((t2 * u) >> 30);
      y = (t * u) >> 30;
      if (y > 64'd1073741824) y = 64'd1073741824;
      return quad[1] ? -longint'(y) : longint'(y);
   endfunction

   // structure factor for one q under the current register settings
   function automatic factor_type predict_factor(input logic [23:0] q);
      factor_type r;
      logic [127:0] prod;
      longint unsigned n, s, a, b, c, qs, x;
      longint pf, om, om2, om4, a1, a2, ho, hop, cb, cg, sum, tt, den, sv;
      longint f, f2, f3, poly, sinc;
      logic [31:0] ph;
      r.q = q;
      r.value = S_MAX;
      r.oor = 1'b1;
      n = steps_reg;
      if (n == 0) n = 1;
      if (n > MAX_STEPS) n = MAX_STEPS;
      s = diameter_reg;
      a = (64'(density_reg) * s) >> 16;
      prod = 128'(a) * 128'(s);
      if (prod[127:64] != 0) return r;
      b = prod[63:0] >> 16;
      prod = 128'(b) * 128'(s);
      if (prod[127:64] != 0) return r;
      c = prod[63:0] >> 8;
      prod = 128'(c) * 128'(PI6_Q32);
      if (prod[127:64] != 0) return r;
      pf = longint'(prod[63:0] >> 36);
      om = ONE_F - pf;
      om2 = (om * om) >>> 28;
      om4 = (om2 * om2) >>> 28;
      a1 = ONE_F + 2 * pf;
      ho = (a1 * a1) >>> 28;
      a2 = ONE_F + (pf >>> 1);
      hop = (a2 * a2) >>> 28;
      cb = 6 * ((pf * hop) >>> 28);
      cg = (pf * ho) >>> 29;
      qs = (64'(q) * s) >> 16;
      sum = 0;
      for (longint unsigned i = 1; i <= n; i++) begin
         f = longint'((i << 28) / n);
         f2 = (f * f) >>> 28;
         f3 = (f2 * f) >>> 28;
         poly = -ho + ((cb * f) >>> 28) - ((cg * f3) >>> 28);
         x = (i * qs) / n;
         if (x == 0) begin
            sinc = ONE_S30;   // sinc at zero is exactly one
         end else begin
            ph = 32'((x * TURN_RATE) >> 16);
            sinc = (sine_q30(ph) * 65536) / longint'(x);
            if (sinc > ONE_S30) sinc = ONE_S30;
            if (sinc < -ONE_S30) sinc = -ONE_S30;
         end
         sum += (((f2 * sinc) >>> 30) * poly) >>> 28;
      end
      tt = sum / longint'(n);
      den = om4 - 24 * ((pf * tt) >>> 28);
      if (den <= 0) return r;
      sv = (om4 * 16777216) / den;
      if (sv > S_TOP) sv = S_TOP;
      r.value = sv[31:0];
      r.oor = 1'b0;
      return r;
   endfunction

   // mostly short idles, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= !calm && $urandom_range(0, 1);
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      factor_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (factor_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%h oor=%b",
                        rsp_factor_value, rsp_out_of_range);
         end else begin
            want = factor_queue.pop_front();
            if (rsp_factor_value !== want.value || rsp_out_of_range !== want.oor) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("q=%h expected value=%h oor=%b actual value=%h oor=%b",
                           want.q, want.value, want.oor, rsp_factor_value,
                           rsp_out_of_range);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL hard_sphere_structure_factor");
         $finish;
      end
   end

   // send one request and hold it until accepted, then idle for a random gap, possibly none
   task automatic send_q(input logic [23:0] q);
      int gap;
      req_valid <= 1'b1;
      req_scatter_q <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      factor_queue.push_back(predict_factor(q));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (factor_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_N_STEPS:  steps_reg = value[12:0];
         CSR_DIAMETER: diameter_reg = value[23:0];
         CSR_DENSITY:  density_reg = value;
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] n, input logic [31:0] sig,
                                input logic [31:0] rho);
      drain();
      write_reg(CSR_N_STEPS, n);
      write_reg(CSR_DIAMETER, sig);
      write_reg(CSR_DENSITY, rho);
   endtask

   // defaults after reset: zero density gives S = 1
   task automatic test_register_defaults();
      send_q(24'd0);
      send_q(24'hFFFFFF);
      send_q(24'h010000);
   endtask

   // step count clamping and the largest count, the large ones at q = 0 to keep them short
   task automatic test_step_limits();
      apply_setting(32'd0, 32'h010000, 32'h00800000);
      send_q(24'h020000);
      apply_setting(32'd4096, 32'h010000, 32'h00800000);
      send_q(24'd0);
      apply_setting(32'd8191, 32'h010000, 32'h00800000);
      send_q(24'd0);
   endtask

   task automatic test_directed_cases();
      // zero diameter
      apply_setting(32'd3, 32'd0, 32'hFFFFFFFF);
      send_q(24'hFFFFFF);
      // packing fraction overflow, diameter and density at their maxima
      apply_setting(32'd4, 32'hFFFFFF, 32'hFFFFFFFF);
      send_q(24'h123456);
      // packing fraction close to one: vanishing (1-pf)^4, sign of den
      apply_setting(32'd5, 32'h010000, 32'h01E80000);
      send_q(24'd0);
      send_q(24'h030000);
      send_q(24'h048000);
      send_q(24'hFFFFFF);
      // moderate pf, sweep of q
      apply_setting(32'd8, 32'h010000, 32'h00C00000);
      send_q(24'd0);
      send_q(24'd1);
      send_q(24'h040000);
      send_q(24'h080000);
      send_q(24'hFFFFFF);
      apply_setting(32'd1, 32'd1, 32'd1);
      send_q(24'hFFFFFF);
   endtask

   // random settings; small step counts keep the run short
   task automatic test_random_settings();
      logic [31:0] n, sig, rho;
      logic [23:0] q;
      int r;
      for (int phase = 0; phase < 24; phase++) begin
         r = $urandom_range(0, 9);
         n = (r < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         if (phase == 5) n = 32'h1FFF & $urandom;
         if (n > 64) n = 64;
         sig = $urandom_range(0, 3) == 0 ? ($urandom & 32'hFFFFFF)
                                         : $urandom_range(16'h4000, 24'h020000);
         rho = $urandom >> $urandom_range(0, 31);
         if (phase == 7) rho = 32'hFFFFFFFF;
         if (phase == 8) rho = 32'd0;
         apply_setting(n, sig, rho);
         calm = (phase % 6 == 3);
         for (int k = 0; k < 25; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) q = 24'd0;
            else if (r == 1) q = 24'hFFFFFF;
            else q = 24'($urandom >> $urandom_range(8, 23));
            send_q(q);
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      steps_reg = 13'd100;
      diameter_reg = 24'd65536;
      density_reg = 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_step_limits();
      test_directed_cases();
      test_random_settings();
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && factor_queue.size() == 0) begin
         $display("PASS hard_sphere_structure_factor");
      end else begin
         $display("FAIL hard_sphere_structure_factor");
      end
      $finish;
   end

endmodule
